FILE: design/rqs_pkg.sv
// Shared types, sizes and codes for the retry queue scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package rqs_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam int TIME_W      = 32;
  localparam int CHAN_W      = 4;
  localparam int TAG_W       = 16;
  localparam int OUT_COUNT_W = 4;
  localparam int CFG_IDX_W   = 2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_CHECK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIMEOUT   = 2'd2;

  localparam logic [TIME_W-1:0] RETRY_INTERVAL_RST = 32'd60000;
  localparam logic [TIME_W-1:0] WAIT_CHECK_RST     = 32'd30000;
  localparam logic [TIME_W-1:0] WAIT_TIMEOUT_RST   = 32'd300000;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_SEND_CHAIN = 2'd1,
    ACT_SEND_CHAN  = 2'd2,
    ACT_SEND_ANON  = 2'd3
  } action_t;

  typedef enum logic {
    REQ_ENQUEUE = 1'b0,
    REQ_TICK    = 1'b1
  } req_kind_t;

  typedef enum logic {
    RSN_SEND_FAILED = 1'b0,
    RSN_WAIT_NUMBER = 1'b1
  } reason_t;

  typedef struct packed {
    req_kind_t           req_type;
    logic [CHAN_W-1:0]   channel;
    logic                full_chain;
    logic [TAG_W-1:0]    payload_tag;
    reason_t             reason;
    logic [TIME_W-1:0]   now_ms;
    logic                number_ready;
    logic                send_ok;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic                chain;
    logic [TAG_W-1:0]    tag;
    reason_t             reason;
    logic [TIME_W-1:0]   enqueue_time;
    logic [TIME_W-1:0]   next_time;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0]   retry_interval;
    logic [TIME_W-1:0]   wait_check;
    logic [TIME_W-1:0]   wait_timeout;
  } cfg_t;

  typedef struct packed {
    action_t                  action;
    logic [CHAN_W-1:0]        out_channel;
    logic [TAG_W-1:0]         out_tag;
    logic                     dropped_oldest;
    logic [OUT_COUNT_W-1:0]   queue_count;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    idx;
    entry_t              entry;
  } slot_wr_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/rqs_slots.sv
// Queue slot storage: one register row per entry, one write port, read at head.
// Depends on rqs_pkg.
`default_nettype none

module rqs_slots
  import rqs_pkg::*;
(
  input  wire logic             clk,
  input  wire slot_wr_t         wr,
  input  wire logic [IDX_W-1:0] head,
  output entry_t                head_entry
);

  entry_t slots [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      slots[wr.idx] <= wr.entry;
    end
  end

  assign head_entry = slots[head];

endmodule

`default_nettype wire

FILE: design/rqs_decide.sv
// Per-request decision logic: enqueue placement, head timer checks, pop and reschedule.
// Depends on rqs_pkg.
`default_nettype none

module rqs_decide
  import rqs_pkg::*;
(
  input  wire req_t             req,
  input  wire cfg_t             cfg,
  input  wire logic [IDX_W-1:0] head,
  input  wire logic [CNT_W-1:0] count,
  input  wire entry_t           head_entry,
  output slot_wr_t              wr,
  output logic [IDX_W-1:0]      head_next,
  output logic [CNT_W-1:0]      count_next,
  output result_t               res
);

  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail;
  logic [TIME_W-1:0] age;
  logic              timed_out;
  logic              due;
  logic              full;
  logic              pop;

  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  assign age       = req.now_ms - head_entry.enqueue_time;
  assign timed_out = age > cfg.wait_timeout;
  assign due       = req.now_ms >= head_entry.next_time;
  assign full      = count == CNT_W'(QUEUE_DEPTH);

  always_comb begin
    wr                 = '{we: 1'b0, idx: head, entry: head_entry};
    head_next          = head;
    count_next         = count;
    pop                = 1'b0;
    res.action         = ACT_NONE;
    res.out_channel    = '0;
    res.out_tag        = '0;
    res.dropped_oldest = 1'b0;

    if (req.req_type == REQ_ENQUEUE) begin
      wr.we                 = 1'b1;
      wr.entry.channel      = req.channel;
      wr.entry.chain        = req.full_chain;
      wr.entry.tag          = req.payload_tag;
      wr.entry.reason       = req.reason;
      wr.entry.enqueue_time = req.now_ms;
      wr.entry.next_time    = req.now_ms + cfg.retry_interval;
      if (full) begin
        // overwrite oldest in place and advance head
        wr.idx             = head;
        head_next          = idx_inc(head);
        res.dropped_oldest = 1'b1;
      end else begin
        wr.idx     = tail;
        count_next = count + 1'b1;
      end
    end else if (count != '0) begin
      if (head_entry.reason == RSN_WAIT_NUMBER) begin
        if (timed_out) begin
          res.action      = head_entry.chain ? ACT_SEND_CHAIN : ACT_SEND_ANON;
          res.out_channel = head_entry.chain ? '0 : head_entry.channel;
          res.out_tag     = head_entry.tag;
          pop             = 1'b1;
        end else if (req.number_ready) begin
          res.out_tag = head_entry.tag;
          if (head_entry.chain) begin
            res.action = ACT_SEND_CHAIN;
            pop        = 1'b1;
          end else begin
            res.action      = ACT_SEND_CHAN;
            res.out_channel = head_entry.channel;
            if (req.send_ok) begin
              pop = 1'b1;
            end else begin
              wr.we              = 1'b1;
              wr.entry.reason    = RSN_SEND_FAILED;
              wr.entry.next_time = req.now_ms + cfg.retry_interval;
            end
          end
        end else if (due) begin
          wr.we              = 1'b1;
          wr.entry.next_time = req.now_ms + cfg.wait_check;
        end
      end else if (due) begin
        res.action      = ACT_SEND_CHAN;
        res.out_channel = head_entry.channel;
        res.out_tag     = head_entry.tag;
        if (req.send_ok) begin
          pop = 1'b1;
        end else begin
          wr.we              = 1'b1;
          wr.entry.next_time = req.now_ms + cfg.retry_interval;
        end
      end
      if (pop) begin
        head_next  = idx_inc(head);
        count_next = count - 1'b1;
      end
    end
    res.queue_count = OUT_COUNT_W'(count_next);
  end

endmodule

`default_nettype wire

FILE: design/retry_queue_scheduler.sv
// Retry queue scheduler top level: stream ports, config registers, request and result stages.
// Depends on rqs_pkg, rqs_slots and rqs_decide.
// A request is registered in the request stage, its result in the result stage; each request
// reads or writes one slot with one add/compare, one request per cycle unless m_tready stalls.
// Reset clears head, count and both stage valids, and loads the register reset values.
// Slot contents are not cleared; only held entries are ever read.
`default_nettype none

module retry_queue_scheduler
  import rqs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [TIME_W-1:0]     cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // channel[3:0], full_chain[4], payload_tag[20:5], reason[21], now_ms[53:22],
  // number_ready[54], send_ok[55]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[0]
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // action[1:0], out_channel[5:2], out_tag[21:6], dropped_oldest[22],
  // queue_count[26:23], zero[31:27]
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  cfg_t             cfg;
  logic             req_valid;
  req_t             req;
  logic             res_valid;
  result_t          res;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;

  req_t             req_in;
  entry_t           head_entry;
  slot_wr_t         wr;
  slot_wr_t         wr_gated;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] count_next;
  result_t          res_next;
  logic             advance;

  assign req_in = '{
    req_type:     req_kind_t'(s_tuser),
    channel:      s_tdata[3:0],
    full_chain:   s_tdata[4],
    payload_tag:  s_tdata[20:5],
    reason:       reason_t'(s_tdata[21]),
    now_ms:       s_tdata[53:22],
    number_ready: s_tdata[54],
    send_ok:      s_tdata[55]
  };

  assign advance  = req_valid && (!res_valid || m_tready);
  assign s_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_interval <= RETRY_INTERVAL_RST;
      cfg.wait_check     <= WAIT_CHECK_RST;
      cfg.wait_timeout   <= WAIT_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RETRY_INTERVAL: cfg.retry_interval <= cfg_wdata;
        REG_WAIT_CHECK:     cfg.wait_check     <= cfg_wdata;
        REG_WAIT_TIMEOUT:   cfg.wait_timeout   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
      head      <= '0;
      count     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
        head      <= head_next;
        count     <= count_next;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req <= req_in;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  rqs_decide u_decide (
    .req        (req),
    .cfg        (cfg),
    .head       (head),
    .count      (count),
    .head_entry (head_entry),
    .wr         (wr),
    .head_next  (head_next),
    .count_next (count_next),
    .res        (res_next)
  );

  always_comb begin
    wr_gated    = wr;
    wr_gated.we = wr.we && advance;
  end

  rqs_slots u_slots (
    .clk        (clk),
    .wr         (wr_gated),
    .head       (head),
    .head_entry (head_entry)
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = {5'd0, res.queue_count, res.dropped_oldest, res.out_tag,
                     res.out_channel, res.action};

endmodule

`default_nettype wire

FILE: design/rqs_checker.sv
// Port-level checks on the result stream of the retry queue scheduler, bound to the top.
// Depends on rqs_pkg and retry_queue_scheduler.
`default_nettype none

module rqs_checker
  import rqs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ACT_NONE |-> m_tdata[21:2] == '0)
    else $error("no-action result carries channel or tag");

  a_chain_channel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ACT_SEND_CHAIN |-> m_tdata[5:2] == '0)
    else $error("chain send carries a channel");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22] |->
      m_tdata[26:23] == OUT_COUNT_W'(QUEUE_DEPTH) && m_tdata[1:0] == ACT_NONE)
    else $error("drop reported without a full queue");

  a_tick_send_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ACT_NONE |-> !m_tdata[22])
    else $error("send result with a drop flag");

endmodule

bind retry_queue_scheduler rqs_checker u_rqs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for retry_queue_scheduler: a directed request table, then randomized phases,
// each result checked against a row or an in-bench retry FIFO model. Depends on rqs_pkg.

module tb_top;
  import rqs_pkg::*;

  typedef struct {
    req_t    req;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [TIME_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  entry_t            held [QUEUE_DEPTH];
  int                head_slot  = 0;
  int                held_count = 0;
  logic [TIME_W-1:0] retry_ms   = RETRY_INTERVAL_RST;
  logic [TIME_W-1:0] check_ms   = WAIT_CHECK_RST;
  logic [TIME_W-1:0] timeout_ms = WAIT_TIMEOUT_RST;
  logic [TIME_W-1:0] clock_ms   = '0;

  result_t   outcome_fifo [$];
  stim_row_t directed_rows [$];
  int        error_count        = 0;
  int        sender_idle_pct    = 0;
  int        receiver_stall_pct = 0;

  retry_queue_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t retry_decision(input req_t r);
    result_t           res;
    int                slot;
    logic [TIME_W-1:0] age;
    bit                pop;
    res = '0;
    pop = 1'b0;
    if (r.req_type == REQ_ENQUEUE) begin
      if (held_count >= QUEUE_DEPTH) begin
        head_slot = (head_slot + 1) % QUEUE_DEPTH;
        held_count--;
        res.dropped_oldest = 1'b1;
      end
      slot = (head_slot + held_count) % QUEUE_DEPTH;
      held[slot].channel      = r.channel;
      held[slot].chain        = r.full_chain;
      held[slot].tag          = r.payload_tag;
      held[slot].reason       = r.reason;
      held[slot].enqueue_time = r.now_ms;
      held[slot].next_time    = r.now_ms + retry_ms;
      held_count++;
    end else if (held_count > 0) begin
      slot = head_slot;
      if (held[slot].reason == RSN_WAIT_NUMBER) begin
        age = r.now_ms - held[slot].enqueue_time;
        if (age > timeout_ms) begin
          res.action      = held[slot].chain ? ACT_SEND_CHAIN : ACT_SEND_ANON;
          res.out_channel = held[slot].chain ? '0 : held[slot].channel;
          res.out_tag     = held[slot].tag;
          pop = 1'b1;
        end else if (r.number_ready) begin
          res.out_tag = held[slot].tag;
          if (held[slot].chain) begin
            res.action = ACT_SEND_CHAIN;
            pop = 1'b1;
          end else begin
            res.action      = ACT_SEND_CHAN;
            res.out_channel = held[slot].channel;
            if (r.send_ok) begin
              pop = 1'b1;
            end else begin
              held[slot].reason    = RSN_SEND_FAILED;
              held[slot].next_time = r.now_ms + retry_ms;
            end
          end
        end else if (r.now_ms >= held[slot].next_time) begin
          held[slot].next_time = r.now_ms + check_ms;
        end
      end else if (r.now_ms >= held[slot].next_time) begin
        res.action      = ACT_SEND_CHAN;
        res.out_channel = held[slot].channel;
        res.out_tag     = held[slot].tag;
        if (r.send_ok) begin
          pop = 1'b1;
        end else begin
          held[slot].next_time = r.now_ms + retry_ms;
        end
      end
      if (pop) begin
        head_slot = (head_slot + 1) % QUEUE_DEPTH;
        held_count--;
      end
    end
    res.queue_count = OUT_COUNT_W'(held_count);
    return res;
  endfunction

  function automatic req_t enqueue_req(input logic [CHAN_W-1:0] chan, input logic chain,
                                       input logic [TAG_W-1:0] tag, input reason_t why,
                                       input logic [TIME_W-1:0] now_ms);
    req_t r;
    r = '0;
    r.req_type    = REQ_ENQUEUE;
    r.channel     = chan;
    r.full_chain  = chain;
    r.payload_tag = tag;
    r.reason      = why;
    r.now_ms      = now_ms;
    return r;
  endfunction

  function automatic req_t tick_req(input logic [TIME_W-1:0] now_ms, input logic ready,
                                    input logic ok);
    req_t r;
    r = '0;
    r.req_type     = REQ_TICK;
    r.now_ms       = now_ms;
    r.number_ready = ready;
    r.send_ok      = ok;
    return r;
  endfunction

  function automatic result_t idle_result(input int count, input logic dropped);
    result_t r;
    r = '0;
    r.action         = ACT_NONE;
    r.dropped_oldest = dropped;
    r.queue_count    = OUT_COUNT_W'(count);
    return r;
  endfunction

  task automatic add_row(input req_t r, input bit typed, input result_t want);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_request(input req_t r, input bit typed, input result_t want);
    result_t predicted;
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.send_ok, r.number_ready, r.now_ms, r.reason, r.payload_tag,
                 r.full_chain, r.channel};
    s_tuser  <= r.req_type;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = retry_decision(r);
    outcome_fifo.push_back(typed ? want : predicted);
  endtask

  // hold off until every request has its result, then let the pipe settle
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outcome_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_timers(input logic [TIME_W-1:0] retry, input logic [TIME_W-1:0] check,
                                input logic [TIME_W-1:0] timeout);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_RETRY_INTERVAL;
    cfg_wdata <= retry;
    @(posedge clk);
    cfg_addr  <= REG_WAIT_CHECK;
    cfg_wdata <= check;
    @(posedge clk);
    cfg_addr  <= REG_WAIT_TIMEOUT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_we    <= 1'b0;
    retry_ms   = retry;
    check_ms   = check;
    timeout_ms = timeout;
  endtask

  task automatic random_phase(input int items, input int step_max);
    req_t r;
    int   enq_pct;
    enq_pct = $urandom_range(25, 60);
    repeat (items) begin
      r.req_type    = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_TICK;
      r.channel     = CHAN_W'($urandom_range(0, 15));
      r.full_chain  = 1'($urandom_range(0, 1));
      r.payload_tag = TAG_W'($urandom());
      r.reason      = reason_t'($urandom_range(0, 1));
      if ($urandom_range(0, 49) == 0) begin
        clock_ms = $urandom();
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
      end
      r.now_ms       = clock_ms;
      r.number_ready = ($urandom_range(0, 99) < 30);
      r.send_ok      = 1'($urandom_range(0, 1));
      send_request(r, 1'b0, '0);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_fifo.size() == 0) begin
        $error("result %h with no request outstanding", m_tdata);
        error_count++;
      end else begin
        want = outcome_fifo.pop_front();
        compare_field("action", want.action, m_tdata[1:0]);
        compare_field("out_channel", want.out_channel, m_tdata[5:2]);
        compare_field("out_tag", want.out_tag, m_tdata[21:6]);
        compare_field("dropped_oldest", want.dropped_oldest, m_tdata[22]);
        compare_field("queue_count", want.queue_count, m_tdata[26:23]);
        compare_field("pad", 32'd0, m_tdata[31:27]);
      end
    end
  end

  initial begin
    int k;
    int step_max;
    add_row(tick_req(32'd0, 1'b0, 1'b0), 1'b1, idle_result(0, 1'b0));
    add_row(enqueue_req(4'hF, 1'b0, 16'hFFFF, RSN_SEND_FAILED, 32'd0), 1'b1,
            idle_result(1, 1'b0));
    add_row(tick_req(32'd59999, 1'b1, 1'b1), 1'b0, '0);
    add_row(tick_req(32'd60000, 1'b0, 1'b0), 1'b0, '0);
    add_row(tick_req(32'd120000, 1'b0, 1'b1), 1'b0, '0);
    add_row(enqueue_req(4'h0, 1'b1, 16'h0000, RSN_WAIT_NUMBER, 32'd1000), 1'b1,
            idle_result(1, 1'b0));
    add_row(tick_req(32'd61000, 1'b0, 1'b1), 1'b0, '0);
    add_row(tick_req(32'd70000, 1'b1, 1'b0), 1'b0, '0);
    add_row(enqueue_req(4'h5, 1'b0, 16'h1234, RSN_WAIT_NUMBER, 32'd0), 1'b1,
            idle_result(1, 1'b0));
    add_row(tick_req(32'd300000, 1'b0, 1'b0), 1'b0, '0);
    add_row(tick_req(32'd300001, 1'b1, 1'b1), 1'b0, '0);
    add_row(enqueue_req(4'h9, 1'b0, 16'hAAAA, RSN_WAIT_NUMBER, 32'hFFFF_FFF0), 1'b1,
            idle_result(1, 1'b0));
    add_row(tick_req(32'h0000_0010, 1'b1, 1'b0), 1'b0, '0);
    add_row(tick_req(32'd60016, 1'b0, 1'b1), 1'b0, '0);
    add_row(enqueue_req(4'hA, 1'b1, 16'h5555, RSN_WAIT_NUMBER, 32'd0), 1'b1,
            idle_result(1, 1'b0));
    add_row(tick_req(32'd300001, 1'b0, 1'b0), 1'b0, '0);
    add_row(enqueue_req(4'h7, 1'b1, 16'h0F0F, RSN_SEND_FAILED, 32'hFFFF_FFFF), 1'b1,
            idle_result(1, 1'b0));
    add_row(tick_req(32'hFFFF_FFFF, 1'b0, 1'b1), 1'b0, '0);
    // fill to depth, then overflow once
    for (k = 0; k <= QUEUE_DEPTH; k++) begin
      add_row(enqueue_req(CHAN_W'(15 - k), 1'(k), TAG_W'(k * 16'h1111), RSN_SEND_FAILED,
                          TIME_W'(k * 7)), 1'b1,
              idle_result((k < QUEUE_DEPTH) ? k + 1 : QUEUE_DEPTH, k == QUEUE_DEPTH));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          program_timers(32'd0, 32'd0, 32'd0);
          step_max = 3;
        end
        1: begin
          program_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          step_max = 1000;
        end
        2: begin
          program_timers($urandom_range(1, 50), $urandom_range(1, 50), $urandom_range(20, 400));
          step_max = 20;
        end
        3: begin
          program_timers(32'd0, 32'hFFFF_FFFF, 32'd0);
          step_max = 5;
        end
        4: begin
          program_timers(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE);
          step_max = 10;
        end
        5: begin
          program_timers($urandom_range(1, 200), $urandom_range(1, 200),
                         $urandom_range(50, 2000));
          step_max = 40;
        end
        6: begin
          program_timers(RETRY_INTERVAL_RST, WAIT_CHECK_RST, WAIT_TIMEOUT_RST);
          step_max = 20000;
        end
        default: begin
          program_timers($urandom(), $urandom(), $urandom());
          step_max = 1 << 20;
        end
      endcase
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 85;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 85;
        end
        default: begin
          sender_idle_pct    = 10;
          receiver_stall_pct = 10;
        end
      endcase
      clock_ms = (p % 2) ? 32'hFFFF_FC00 : TIME_W'($urandom_range(0, 1000));
      random_phase(240, step_max);
    end

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
